// ===== sv/swmf_pkg.sv =====
`timescale 1ns / 1ps

package swmf_pkg;

  localparam int CFG_W            = 6;
  localparam int CFG_TW           = ((CFG_W + 7) / 8) * 8;
  localparam int WINDOW_MAX_DEF   = 32;
  localparam int SAMPLE_WIDTH_DEF = 16;

  localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = CFG_W'(5);

  typedef struct packed {
    logic load;
    logic clear;
    logic full;
  } swmf_ctl_t;

endpackage

// ===== sv/sliding_window_median_filter.sv =====
`timescale 1ns / 1ps

// Running median filter over a sliding window of signed samples.
// Samples arrive as beats on the in_ stream; each accepted beat yields exactly
// one beat on the out_ stream carrying twice the median of the samples held
// so far and the number of samples it was taken over. While the window fills,
// the median covers all samples since the last clear; afterwards it covers the
// last window_size samples, with zero taken as one and WINDOW_MAX as the cap.
// The window is a row of cells kept in sorted order. Each accepted sample
// is inserted in place and, once the window is full, evicts the oldest entry,
// so the block takes one beat per clock while the receiver does not stall.
// The cells take the sample as its input beat is accepted; the middle entries
// are then selected into the output register once it is free, and it drives out_.
// When the receiver stalls, the finished result waits in the output register
// and one more sample may be taken into the cells; after that in_tready stays
// low until the output register is freed.
// The cfg_ stream writes window_size and empties the window; the user must
// write it only while the block is idle, which the block does not enforce.
// Reset empties the window and sets the window size to five.

module sliding_window_median_filter import swmf_pkg::*; #(
  parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           in_tvalid,
  output logic                                           in_tready,
  // Fields from bit 0: sample.
  input  logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0]      in_tdata,
  output logic                                           out_tvalid,
  input  logic                                           out_tready,
  // Fields from bit 0: median_twice, held_count.
  output logic [((SAMPLE_WIDTH + 1 + CFG_W + 7) / 8) * 8 - 1:0] out_tdata,
  input  logic                                           cfg_tvalid,
  output logic                                           cfg_tready,
  // Fields from bit 0: window_size.
  input  logic [CFG_TW-1:0]                              cfg_tdata
);

  localparam int AW     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int IW     = $clog2(WINDOW_MAX + 1);
  localparam int OW     = SAMPLE_WIDTH + 1;
  localparam int OUT_TW = ((OW + CFG_W + 7) / 8) * 8;

  logic [CFG_W-1:0]  window_size_r;
  logic [CFG_W-1:0]  fill_count_r, fill_count_nxt;
  logic              pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_TW-1:0] out_data_r, out_data_nxt;

  logic [CFG_W-1:0]  size_eff;
  logic [AW-1:0]     evict_age;
  logic              in_acc, cfg_acc, out_move;
  swmf_ctl_t         ctl;

  logic signed [SAMPLE_WIDTH-1:0] x;
  logic signed [SAMPLE_WIDTH-1:0] a_val   [WINDOW_MAX+1];
  logic [AW-1:0]                  a_age   [WINDOW_MAX+1];
  logic                           a_valid [WINDOW_MAX+1];
  logic signed [SAMPLE_WIDTH-1:0] r_val   [WINDOW_MAX+1];
  logic [AW-1:0]                  r_age   [WINDOW_MAX+1];
  logic                           r_valid [WINDOW_MAX+1];
  logic                           r_le    [WINDOW_MAX+1];
  logic                           r_past  [WINDOW_MAX+1];

  logic [IW-1:0]                  lo_idx, hi_idx;
  logic signed [OW-1:0]           median_twice;

  always_comb begin
    if (window_size_r == '0) begin
      size_eff = CFG_W'(1);
    end else if (int'(window_size_r) > WINDOW_MAX) begin
      size_eff = CFG_W'(WINDOW_MAX);
    end else begin
      size_eff = window_size_r;
    end
  end

  assign evict_age = AW'(size_eff - CFG_W'(1));
  assign x         = in_tdata[SAMPLE_WIDTH-1:0];
  assign cfg_tready = 1'b1;
  assign cfg_acc    = cfg_tvalid;
  assign out_move   = pend_r & (!out_valid_r | out_tready);
  assign in_tready  = !pend_r | out_move;
  assign in_acc     = in_tvalid & in_tready;

  assign ctl.load  = in_acc;
  assign ctl.clear = cfg_acc;
  assign ctl.full  = (fill_count_r == size_eff);

  assign a_val[WINDOW_MAX]   = '0;
  assign a_age[WINDOW_MAX]   = '0;
  assign a_valid[WINDOW_MAX] = 1'b0;
  assign r_val[0]            = '0;
  assign r_age[0]            = '0;
  assign r_valid[0]          = 1'b0;
  assign r_le[0]             = 1'b1;
  assign r_past[0]           = 1'b0;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    swmf_cell #(
      .SW (SAMPLE_WIDTH),
      .AW (AW)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .evict_age   (evict_age),
      .x           (x),
      .left_val    (r_val[i]),
      .left_age    (r_age[i]),
      .left_valid  (r_valid[i]),
      .left_le     (r_le[i]),
      .left_past   (r_past[i]),
      .right_val   (a_val[i+1]),
      .right_age   (a_age[i+1]),
      .right_valid (a_valid[i+1]),
      .val         (a_val[i]),
      .age         (a_age[i]),
      .valid       (a_valid[i]),
      .r_val       (r_val[i+1]),
      .r_age       (r_age[i+1]),
      .r_valid     (r_valid[i+1]),
      .r_le        (r_le[i+1]),
      .past        (r_past[i+1])
    );
  end

  // For an odd count both indexes meet at the middle entry.
  assign lo_idx = IW'((fill_count_r - CFG_W'(1)) >> 1);
  assign hi_idx = IW'(fill_count_r >> 1);
  assign median_twice = {a_val[lo_idx][SAMPLE_WIDTH-1], a_val[lo_idx]}
                      + {a_val[hi_idx][SAMPLE_WIDTH-1], a_val[hi_idx]};

  always_comb begin
    fill_count_nxt = fill_count_r;
    if (cfg_acc) begin
      fill_count_nxt = '0;
    end else if (in_acc && !ctl.full) begin
      fill_count_nxt = fill_count_r + CFG_W'(1);
    end

    pend_nxt = pend_r;
    if (in_acc) begin
      pend_nxt = 1'b1;
    end else if (out_move) begin
      pend_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_move) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = OUT_TW'({fill_count_r, median_twice});
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WINDOW_SIZE_RESET;
      fill_count_r  <= '0;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_acc) begin
        window_size_r <= cfg_tdata[CFG_W-1:0];
      end
      fill_count_r <= fill_count_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== sv/swmf_cell.sv =====
`timescale 1ns / 1ps

module swmf_cell import swmf_pkg::*; #(
  parameter int SW = SAMPLE_WIDTH_DEF,
  parameter int AW = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  swmf_ctl_t            ctl,
  input  logic [AW-1:0]        evict_age,
  input  logic signed [SW-1:0] x,
  input  logic signed [SW-1:0] left_val,
  input  logic [AW-1:0]        left_age,
  input  logic                 left_valid,
  input  logic                 left_le,
  input  logic                 left_past,
  input  logic signed [SW-1:0] right_val,
  input  logic [AW-1:0]        right_age,
  input  logic                 right_valid,
  output logic signed [SW-1:0] val,
  output logic [AW-1:0]        age,
  output logic                 valid,
  output logic signed [SW-1:0] r_val,
  output logic [AW-1:0]        r_age,
  output logic                 r_valid,
  output logic                 r_le,
  output logic                 past
);

  logic signed [SW-1:0] val_r, val_nxt;
  logic [AW-1:0]        age_r, age_nxt;
  logic                 valid_r, valid_nxt;
  logic                 evict;

  // A cell at or after the evicted one takes its right neighbor's entry.
  assign evict   = valid_r & ctl.full & (age_r == evict_age);
  assign past    = left_past | evict;
  assign r_val   = past ? right_val : val_r;
  assign r_age   = past ? right_age : age_r;
  assign r_valid = past ? right_valid : valid_r;
  assign r_le    = r_valid & !(r_val > x);

  always_comb begin
    if (r_le) begin
      val_nxt   = r_val;
      age_nxt   = r_age + AW'(1);
      valid_nxt = 1'b1;
    end else if (left_le) begin
      val_nxt   = x;
      age_nxt   = '0;
      valid_nxt = 1'b1;
    end else begin
      val_nxt   = left_val;
      age_nxt   = left_age + AW'(1);
      valid_nxt = left_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.clear) begin
      valid_r <= 1'b0;
    end else if (ctl.load) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

  assign val   = val_r;
  assign age   = age_r;
  assign valid = valid_r;

endmodule

// ===== verif/tb_sliding_window_median_filter.sv =====
`timescale 1ns / 1ps

module tb_sliding_window_median_filter;
  import swmf_pkg::*;

  localparam int SAMPLE_W = 16;
  localparam int IN_TW    = ((SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_TW   = ((SAMPLE_W + 1 + CFG_W + 7) / 8) * 8;
  localparam int WIN_MAX  = 32;
  localparam int N_ROWS   = 25;
  localparam int N_PHASES = 12;
  localparam int PHASE_LEN = 135;

  typedef enum bit {ROW_SAMPLE, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [15:0]        val;
    bit                 typed;
    logic signed [16:0] twice;
    logic [5:0]         count;
  } stim_row_t;

  typedef struct packed {
    logic signed [16:0] twice;
    logic [5:0]         count;
  } median_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TW-1:0] out_tdata;
  logic cfg_tvalid = 1'b0;
  logic cfg_tready;
  logic [CFG_TW-1:0] cfg_tdata = '0;

  bit calm = 1'b0;
  int err_count = 0;
  int samples_sent = 0;
  int beats_checked = 0;
  int cfg_writes = 0;

  logic signed [15:0] win_store [0:WIN_MAX-1];
  int win_pos = 0;
  int win_fill = 0;
  logic [5:0] win_size_reg = WINDOW_SIZE_RESET;

  median_beat_t median_q [$];

  stim_row_t dir_rows [0:N_ROWS-1] = '{
    '{ROW_SAMPLE, 16'h7FFF, 1'b1, 17'h0FFFE, 6'd1},
    '{ROW_SAMPLE, 16'h8000, 1'b1, 17'h1FFFF, 6'd2},
    '{ROW_SAMPLE, 16'h0000, 1'b1, 17'h00000, 6'd3},
    '{ROW_SAMPLE, 16'h0003, 1'b0, 17'h00000, 6'd0},
    '{ROW_SAMPLE, 16'hFFFD, 1'b0, 17'h00000, 6'd0},
    '{ROW_SAMPLE, 16'h0064, 1'b0, 17'h00000, 6'd0},
    '{ROW_SAMPLE, 16'h0001, 1'b0, 17'h00000, 6'd0},
    '{ROW_CFG,    16'd0,    1'b0, 17'h00000, 6'd0},
    '{ROW_SAMPLE, 16'h8000, 1'b1, 17'h10000, 6'd1},
    '{ROW_SAMPLE, 16'h7FFF, 1'b1, 17'h0FFFE, 6'd1},
    '{ROW_CFG,    16'd1,    1'b0, 17'h00000, 6'd0},
    '{ROW_SAMPLE, 16'h1234, 1'b1, 17'h02468, 6'd1},
    '{ROW_CFG,    16'd2,    1'b0, 17'h00000, 6'd0},
    '{ROW_SAMPLE, 16'h7FFF, 1'b1, 17'h0FFFE, 6'd1},
    '{ROW_SAMPLE, 16'h7FFF, 1'b1, 17'h0FFFE, 6'd2},
    '{ROW_SAMPLE, 16'h8000, 1'b1, 17'h1FFFF, 6'd2},
    '{ROW_CFG,    16'd63,   1'b0, 17'h00000, 6'd0},
    '{ROW_SAMPLE, 16'h8001, 1'b0, 17'h00000, 6'd0},
    '{ROW_SAMPLE, 16'h5555, 1'b0, 17'h00000, 6'd0},
    '{ROW_SAMPLE, 16'hAAAA, 1'b0, 17'h00000, 6'd0},
    '{ROW_CFG,    16'd33,   1'b0, 17'h00000, 6'd0},
    '{ROW_SAMPLE, 16'h0010, 1'b1, 17'h00020, 6'd1},
    '{ROW_SAMPLE, 16'hFFF0, 1'b0, 17'h00000, 6'd0},
    '{ROW_CFG,    16'd32,   1'b0, 17'h00000, 6'd0},
    '{ROW_SAMPLE, 16'hFFFF, 1'b1, 17'h1FFFE, 6'd1}
  };

  sliding_window_median_filter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_tvalid(cfg_tvalid),
    .cfg_tready(cfg_tready),
    .cfg_tdata (cfg_tdata)
  );

  always #1 clk = ~clk;

  task automatic log_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    err_count++;
  endtask

  function automatic median_beat_t median_of_window(input logic signed [15:0] s);
    int span;
    int sorted [0:WIN_MAX-1];
    int v;
    int j;
    int twice;
    median_beat_t r;
    span = (win_size_reg == 0) ? 1 : ((win_size_reg > WIN_MAX) ? WIN_MAX : win_size_reg);
    if (win_pos >= span) win_pos = 0;
    win_store[win_pos] = s;
    win_pos++;
    if (win_pos >= span) win_pos = 0;
    if (win_fill < span) win_fill++;
    if (win_fill > span) win_fill = span;
    for (int i = 0; i < win_fill; i++) begin
      v = win_store[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    if (win_fill % 2 == 1) twice = 2 * sorted[win_fill / 2];
    else twice = sorted[win_fill / 2 - 1] + sorted[win_fill / 2];
    r.twice = twice[16:0];
    r.count = win_fill[5:0];
    return r;
  endfunction

  task automatic push_sample(input logic [15:0] s, input bit typed,
                             input logic signed [16:0] t_twice, input logic [5:0] t_count);
    median_beat_t m;
    in_tdata <= s;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    m = median_of_window(s);
    if (typed) begin
      m.twice = t_twice;
      m.count = t_count;
    end
    median_q.push_back(m);
    samples_sent++;
  endtask

  task automatic quiesce_and_write(input logic [5:0] v);
    in_tvalid <= 1'b0;
    repeat (4) @(posedge clk);
    while (median_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_tdata <= CFG_TW'(v);
    cfg_tvalid <= 1'b1;
    @(posedge clk);
    while (!cfg_tready) @(posedge clk);
    cfg_tvalid <= 1'b0;
    win_size_reg = v;
    win_pos = 0;
    win_fill = 0;
    cfg_writes++;
  endtask

  function automatic logic [15:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      1, 2, 3: return 16'($signed($urandom_range(0, 8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    median_beat_t m;
    if (rst_n && out_tvalid && out_tready) begin
      if (median_q.size() == 0) begin
        log_mismatch($sformatf("unexpected result beat, data 0x%0h", out_tdata));
      end else begin
        m = median_q.pop_front();
        beats_checked++;
        if (out_tdata[16:0] !== m.twice)
          log_mismatch($sformatf("median_twice got %0d expected %0d",
                                 $signed(out_tdata[16:0]), m.twice));
        if (out_tdata[22:17] !== m.count)
          log_mismatch($sformatf("held_count got %0d expected %0d",
                                 out_tdata[22:17], m.count));
      end
    end
  end

  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  initial begin
    #1_000_000;
    $display("Timed out with %0d results outstanding.", median_q.size());
    $display("tb_sliding_window_median_filter: FAIL");
    $finish;
  end

  initial begin
    int gap_pct;
    int waited;
    logic [5:0] sz;
    logic [5:0] fixed_sizes [0:8];
    fixed_sizes = '{6'd1, 6'd32, 6'd2, 6'd0, 6'd63, 6'd33, 6'd5, 6'd31, 6'd3};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        quiesce_and_write(dir_rows[i].val[5:0]);
      end else begin
        push_sample(dir_rows[i].val, dir_rows[i].typed, dir_rows[i].twice, dir_rows[i].count);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      sz = (ph < 9) ? fixed_sizes[ph] : 6'($urandom_range(1, 32));
      quiesce_and_write(sz);
      calm = (ph == N_PHASES - 1);
      gap_pct = (calm || ph % 3 == 0) ? 0 : $urandom_range(5, 40);
      repeat (PHASE_LEN) begin
        push_sample(pick_sample(), 1'b0, '0, '0);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
          in_tvalid <= 1'b0;
          repeat ($urandom_range(1, 13)) @(posedge clk);
        end
      end
    end

    in_tvalid <= 1'b0;
    waited = 0;
    while (median_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (median_q.size() != 0)
      log_mismatch($sformatf("%0d expected results never arrived", median_q.size()));

    $display("Sent %0d samples over %0d window size writes, checked %0d result beats.",
             samples_sent, cfg_writes, beats_checked);
    $display("Window sizes covered 0, 1, 2, 3, 5, 31, 32, 33 and 63, plus random sizes.");
    if (err_count == 0) begin
      $display("tb_sliding_window_median_filter: PASS");
    end else begin
      $display("tb_sliding_window_median_filter: FAIL");
    end
    $finish;
  end

endmodule
